FILE: rtl/core/rfti_pkg.sv
// rfti_pkg: shared constants, item types and saturation helper for the radial field interpolator
`timescale 1ns / 1ps
package rfti_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 1024;

    localparam logic [31:0] RADIUS_SCALE_RESET = 32'd26214400;
    localparam logic [21:0] MAX_RADIUS_RESET   = 22'd1564458;

    localparam logic REG_RADIUS_SCALE = 1'b0;
    localparam logic REG_MAX_RADIUS   = 1'b1;

    localparam logic ACTION_WRITE = 1'b0;
    localparam logic ACTION_QUERY = 1'b1;

    localparam int DIV_BITS   = 56;
    localparam int DIV_STEP   = 4;
    localparam int DIV_STAGES = DIV_BITS / DIV_STEP;

    localparam logic signed [33:0] MAX34 = 34'sh1_FFFF_FFFF;
    localparam logic signed [33:0] MIN34 = 34'sh2_0000_0000;

    typedef struct packed {
        logic [9:0]         entry_index;
        logic signed [31:0] potential_word;
        logic signed [31:0] field_word;
        logic signed [31:0] collision_word;
        logic signed [22:0] pos_x;
        logic signed [22:0] pos_y;
        logic [21:0]        radius;
        logic signed [3:0]  particle_charge;
    } in_item_t;

    typedef struct packed {
        logic               oor;
        logic               zr;
        logic signed [33:0] pot;
        logic signed [33:0] fld;
        logic signed [31:0] col;
        logic signed [22:0] x;
        logic signed [22:0] y;
        logic [21:0]        r;
    } front_t;

    typedef struct packed {
        logic signed [33:0] potential_energy;
        logic signed [33:0] radial_field;
        logic signed [33:0] field_x;
        logic signed [33:0] field_y;
        logic signed [31:0] collision_density;
        logic               out_of_range;
    } out_item_t;

    function automatic logic signed [33:0] sat34(input logic signed [35:0] v);
        logic signed [35:0] hi;
        logic signed [35:0] lo;
        hi = 36'sh1_FFFF_FFFF;
        lo = 36'shE_0000_0000;
        if (v > hi)
            return MAX34;
        else if (v < lo)
            return MIN34;
        else
            return v[33:0];
    endfunction

endpackage

FILE: rtl/core/radial_field_table_interpolator.sv
// radial_field_table_interpolator: top level with config registers and stream packing
//
// channel   dir  signals                          item
// s_axis    in   tvalid tready tdata[183:0] tuser table write or field query
// m_axis    out  tvalid tready tdata[167:0] tuser query result
// cfg       in   cfg_we cfg_index cfg_data        register write
//
// one item per cycle sustained while m_axis accepts results
// a query result passes through six table and interpolation stages, the product stage, fourteen
// divider stages of four quotient bits each, and the output register
// write items update the tables and produce no result
// reset clears all valid bits and loads the register defaults; table contents stay undefined
// a stall on m_axis holds every stage that is full; empty stages keep filling
`timescale 1ns / 1ps
module radial_field_table_interpolator #(
    parameter int TABLE_DEPTH = rfti_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // entry_index, potential_word, field_word, collision_word, pos_x, pos_y,
    // radius, particle_charge, zero pad
    input  logic [183:0] s_axis_tdata,
    // action
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // potential_energy, radial_field, field_x, field_y, collision_density
    output logic [167:0] m_axis_tdata,
    // out_of_range
    output logic         m_axis_tuser,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [31:0]  cfg_data
);

    import rfti_pkg::*;

    logic [31:0] radius_scale_reg;
    logic [21:0] max_radius_reg;

    in_item_t  in_item;
    logic      fr_valid;
    logic      fr_ready;
    front_t    fr_item;
    out_item_t res_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_scale_reg <= RADIUS_SCALE_RESET;
            max_radius_reg   <= MAX_RADIUS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_RADIUS_SCALE: radius_scale_reg <= cfg_data;
                REG_MAX_RADIUS:   max_radius_reg   <= cfg_data[21:0];
                default:          radius_scale_reg <= radius_scale_reg;
            endcase
        end
    end

    always_comb
    begin
        in_item.entry_index     = s_axis_tdata[9:0];
        in_item.potential_word  = s_axis_tdata[41:10];
        in_item.field_word      = s_axis_tdata[73:42];
        in_item.collision_word  = s_axis_tdata[105:74];
        in_item.pos_x           = s_axis_tdata[128:106];
        in_item.pos_y           = s_axis_tdata[151:129];
        in_item.radius          = s_axis_tdata[173:152];
        in_item.particle_charge = s_axis_tdata[177:174];
    end

    rfti_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .in_action    (s_axis_tuser),
        .in_item      (in_item),
        .radius_scale (radius_scale_reg),
        .max_radius   (max_radius_reg),
        .out_valid    (fr_valid),
        .out_ready    (fr_ready),
        .out_item     (fr_item)
    );

    rfti_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_item   (fr_item),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_item  (res_item)
    );

    assign m_axis_tdata = {res_item.collision_density, res_item.field_y, res_item.field_x,
                           res_item.radial_field, res_item.potential_energy};
    assign m_axis_tuser = res_item.out_of_range;

`ifndef SYNTHESIS
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 168'd0)
        else $error("out of range result carries nonzero data");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output register is empty");

    a_zero_field: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[67:34] == 34'd0)
        |-> (m_axis_tdata[101:68] == 34'd0) && (m_axis_tdata[135:102] == 34'd0))
        else $error("field components nonzero with zero radial field");
`endif

endmodule

FILE: rtl/core/rfti_ram.sv
// rfti_ram: generic single-write dual-read memory with registered read data
`timescale 1ns / 1ps
module rfti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

FILE: rtl/core/rfti_front.sv
// rfti_front: table writes, radius scaling, table reads, interpolation and charge scaling
`timescale 1ns / 1ps
module rfti_front #(
    parameter int TABLE_DEPTH = rfti_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              in_action,
    input  rfti_pkg::in_item_t in_item,
    input  logic [31:0]       radius_scale,
    input  logic [21:0]       max_radius,
    output logic              out_valid,
    input  logic              out_ready,
    output rfti_pkg::front_t  out_item
);

    import rfti_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam logic [17:0] LAST_LO = 18'(TABLE_DEPTH - 1);
    localparam logic [17:0] DEPTH18 = 18'(TABLE_DEPTH);

    // stage a: scaled radius
    logic        a_valid_reg;
    logic        a_action_reg;
    in_item_t    a_item_reg;
    logic [53:0] a_prod_reg;
    logic        a_rgt_reg;
    logic [53:0] a_prod_next;

    // stage b: table read issued
    logic              b_valid_reg;
    logic              b_oor_reg;
    logic [15:0]       b_frac_reg;
    logic signed [3:0] b_charge_reg;
    logic signed [22:0] b_x_reg;
    logic signed [22:0] b_y_reg;
    logic [21:0]       b_r_reg;

    // stage c: differences
    logic               c_valid_reg;
    logic               c_oor_reg;
    logic [15:0]        c_frac_reg;
    logic signed [3:0]  c_charge_reg;
    logic signed [22:0] c_x_reg;
    logic signed [22:0] c_y_reg;
    logic [21:0]        c_r_reg;
    logic signed [32:0] c_dpot_reg;
    logic signed [32:0] c_dfld_reg;
    logic signed [31:0] c_lopot_reg;
    logic signed [31:0] c_lofld_reg;
    logic signed [31:0] c_col_reg;

    // stage d: fraction products
    logic               d_valid_reg;
    logic               d_oor_reg;
    logic signed [3:0]  d_charge_reg;
    logic signed [22:0] d_x_reg;
    logic signed [22:0] d_y_reg;
    logic [21:0]        d_r_reg;
    logic signed [49:0] d_mpot_reg;
    logic signed [49:0] d_mfld_reg;
    logic signed [31:0] d_lopot_reg;
    logic signed [31:0] d_lofld_reg;
    logic signed [31:0] d_col_reg;

    // stage e: interpolated values
    logic               e_valid_reg;
    logic               e_oor_reg;
    logic signed [3:0]  e_charge_reg;
    logic signed [22:0] e_x_reg;
    logic signed [22:0] e_y_reg;
    logic [21:0]        e_r_reg;
    logic signed [31:0] e_pot_reg;
    logic signed [31:0] e_fld_reg;
    logic signed [31:0] e_col_reg;

    // stage f: charge scaled output
    logic   f_valid_reg;
    front_t f_item_reg;
    front_t f_item_next;

    logic ready_a;
    logic ready_b;
    logic ready_c;
    logic ready_d;
    logic ready_e;
    logic ready_f;

    logic [17:0]      idx;
    logic             oor_next;
    logic [AW-1:0]    lo_addr;
    logic [AW-1:0]    hi_addr;
    logic [AW+9:0]    entry_wide;
    logic [AW-1:0]    waddr;
    logic             we;
    logic [63:0]      pf_lo;
    logic [63:0]      pf_hi;
    logic [31:0]      col_lo;
    logic [31:0]      col_unused_b;

    logic signed [49:0] sh_pot;
    logic signed [49:0] sh_fld;
    logic signed [33:0] sum_pot;
    logic signed [33:0] sum_fld;
    logic signed [35:0] q_pot;
    logic signed [35:0] q_fld;

    assign ready_f  = !f_valid_reg || out_ready;
    assign ready_e  = !e_valid_reg || ready_f;
    assign ready_d  = !d_valid_reg || ready_e;
    assign ready_c  = !c_valid_reg || ready_d;
    assign ready_b  = !b_valid_reg || ready_c;
    assign ready_a  = !a_valid_reg || ready_b;
    assign in_ready = ready_a;

    assign a_prod_next = 54'(in_item.radius) * 54'(radius_scale);

    assign idx      = a_prod_reg[53:36];
    assign oor_next = (idx >= LAST_LO) || a_rgt_reg;
    assign lo_addr  = idx[AW-1:0];
    assign hi_addr  = lo_addr + AW'(1);

    assign entry_wide = {{AW{1'b0}}, a_item_reg.entry_index};
    assign waddr      = entry_wide[AW-1:0];
    assign we         = a_valid_reg && ready_b && (a_action_reg == ACTION_WRITE)
                        && ({8'b0, a_item_reg.entry_index} < DEPTH18);

    rfti_ram #(
        .WIDTH (64),
        .DEPTH (TABLE_DEPTH)
    ) u_pf_ram (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   ({a_item_reg.field_word, a_item_reg.potential_word}),
        .re      (ready_b),
        .raddr_a (lo_addr),
        .raddr_b (hi_addr),
        .rdata_a (pf_lo),
        .rdata_b (pf_hi)
    );

    rfti_ram #(
        .WIDTH (32),
        .DEPTH (TABLE_DEPTH)
    ) u_col_ram (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (a_item_reg.collision_word),
        .re      (ready_b),
        .raddr_a (lo_addr),
        .raddr_b (lo_addr),
        .rdata_a (col_lo),
        .rdata_b (col_unused_b)
    );

    assign sh_pot  = d_mpot_reg >>> 16;
    assign sh_fld  = d_mfld_reg >>> 16;
    assign sum_pot = $signed({{2{d_lopot_reg[31]}}, d_lopot_reg}) + sh_pot[33:0];
    assign sum_fld = $signed({{2{d_lofld_reg[31]}}, d_lofld_reg}) + sh_fld[33:0];

    assign q_pot = $signed({{32{e_charge_reg[3]}}, e_charge_reg})
                   * $signed({{4{e_pot_reg[31]}}, e_pot_reg});
    assign q_fld = $signed({{32{e_charge_reg[3]}}, e_charge_reg})
                   * $signed({{4{e_fld_reg[31]}}, e_fld_reg});

    always_comb
    begin
        f_item_next.oor = e_oor_reg;
        f_item_next.zr  = (e_r_reg == 22'd0);
        f_item_next.x   = e_x_reg;
        f_item_next.y   = e_y_reg;
        f_item_next.r   = e_r_reg;
        if (e_oor_reg)
        begin
            f_item_next.pot = '0;
            f_item_next.fld = '0;
            f_item_next.col = '0;
        end
        else
        begin
            f_item_next.pot = sat34(q_pot);
            f_item_next.fld = sat34(q_fld);
            f_item_next.col = e_col_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
        end
        else
        begin
            if (ready_a)
                a_valid_reg <= in_valid;
            if (ready_b)
                b_valid_reg <= a_valid_reg && (a_action_reg == ACTION_QUERY);
            if (ready_c)
                c_valid_reg <= b_valid_reg;
            if (ready_d)
                d_valid_reg <= c_valid_reg;
            if (ready_e)
                e_valid_reg <= d_valid_reg;
            if (ready_f)
                f_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_a)
        begin
            a_action_reg <= in_action;
            a_item_reg   <= in_item;
            a_prod_reg   <= a_prod_next;
            a_rgt_reg    <= in_item.radius > max_radius;
        end
        if (ready_b)
        begin
            b_oor_reg    <= oor_next;
            b_frac_reg   <= a_prod_reg[35:20];
            b_charge_reg <= a_item_reg.particle_charge;
            b_x_reg      <= a_item_reg.pos_x;
            b_y_reg      <= a_item_reg.pos_y;
            b_r_reg      <= a_item_reg.radius;
        end
        if (ready_c)
        begin
            c_oor_reg    <= b_oor_reg;
            c_frac_reg   <= b_frac_reg;
            c_charge_reg <= b_charge_reg;
            c_x_reg      <= b_x_reg;
            c_y_reg      <= b_y_reg;
            c_r_reg      <= b_r_reg;
            c_dpot_reg   <= $signed({pf_hi[31], pf_hi[31:0]})
                            - $signed({pf_lo[31], pf_lo[31:0]});
            c_dfld_reg   <= $signed({pf_hi[63], pf_hi[63:32]})
                            - $signed({pf_lo[63], pf_lo[63:32]});
            c_lopot_reg  <= pf_lo[31:0];
            c_lofld_reg  <= pf_lo[63:32];
            c_col_reg    <= col_lo;
        end
        if (ready_d)
        begin
            d_oor_reg    <= c_oor_reg;
            d_charge_reg <= c_charge_reg;
            d_x_reg      <= c_x_reg;
            d_y_reg      <= c_y_reg;
            d_r_reg      <= c_r_reg;
            d_mpot_reg   <= $signed({{17{c_dpot_reg[32]}}, c_dpot_reg})
                            * $signed({34'd0, c_frac_reg});
            d_mfld_reg   <= $signed({{17{c_dfld_reg[32]}}, c_dfld_reg})
                            * $signed({34'd0, c_frac_reg});
            d_lopot_reg  <= c_lopot_reg;
            d_lofld_reg  <= c_lofld_reg;
            d_col_reg    <= c_col_reg;
        end
        if (ready_e)
        begin
            e_oor_reg    <= d_oor_reg;
            e_charge_reg <= d_charge_reg;
            e_x_reg      <= d_x_reg;
            e_y_reg      <= d_y_reg;
            e_r_reg      <= d_r_reg;
            e_pot_reg    <= sum_pot[31:0];
            e_fld_reg    <= sum_fld[31:0];
            e_col_reg    <= d_col_reg;
        end
        if (ready_f)
        begin
            f_item_reg <= f_item_next;
        end
    end

    assign out_valid = f_valid_reg;
    assign out_item  = f_item_reg;

endmodule

FILE: rtl/core/rfti_div.sv
// rfti_div: field times position products and pipelined division by radius
`timescale 1ns / 1ps
module rfti_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  rfti_pkg::front_t    in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output rfti_pkg::out_item_t out_item
);

    import rfti_pkg::*;

    function automatic logic [77:0] div_step(
        input logic [21:0] rem,
        input logic [55:0] qd,
        input logic [21:0] d
    );
        logic [22:0] t;
        logic [21:0] rm;
        logic [55:0] q;
        int          i;
        rm = rem;
        q  = qd;
        for (i = 0; i < DIV_STEP; i++)
        begin
            t = {rm, q[55]};
            q = {q[54:0], 1'b0};
            if (t >= {1'b0, d})
            begin
                rm   = 22'(t - {1'b0, d});
                q[0] = 1'b1;
            end
            else
            begin
                rm = t[21:0];
            end
        end
        return {rm, q};
    endfunction

    function automatic logic signed [33:0] quot_sat(input logic [55:0] q, input logic neg);
        if (!neg)
        begin
            if (q[55:33] != 23'd0)
                return MAX34;
            else
                return $signed(q[33:0]);
        end
        else
        begin
            if ((q[55:34] != 22'd0) || (q[33] && (q[32:0] != 33'd0)))
                return MIN34;
            else
                return $signed(-q[33:0]);
        end
    endfunction

    // product stage
    logic        g_valid_reg;
    front_t      g_item_reg;
    logic [1:0]  g_neg_reg;
    logic [55:0] g_mag_reg [2];

    logic signed [56:0] prod_x;
    logic signed [56:0] prod_y;
    logic signed [56:0] abs_x;
    logic signed [56:0] abs_y;

    // divider stages
    logic [DIV_STAGES-1:0] dv_valid_reg;
    front_t                dv_item_reg [DIV_STAGES];
    logic [1:0]            dv_neg_reg  [DIV_STAGES];
    logic [21:0]           dv_rem_reg  [DIV_STAGES][2];
    logic [55:0]           dv_qd_reg   [DIV_STAGES][2];
    logic [77:0]           dv_step_next [DIV_STAGES][2];
    logic [DIV_STAGES:0]   dv_ready;

    // output register
    logic      o_valid_reg;
    out_item_t o_item_reg;
    out_item_t o_item_next;
    logic      kill;

    logic g_ready;

    assign dv_ready[DIV_STAGES] = !o_valid_reg || out_ready;
    assign g_ready  = !g_valid_reg || dv_ready[0];
    assign in_ready = g_ready;

    assign prod_x = $signed({{23{in_item.fld[33]}}, in_item.fld})
                    * $signed({{34{in_item.x[22]}}, in_item.x});
    assign prod_y = $signed({{23{in_item.fld[33]}}, in_item.fld})
                    * $signed({{34{in_item.y[22]}}, in_item.y});
    assign abs_x  = prod_x[56] ? -prod_x : prod_x;
    assign abs_y  = prod_y[56] ? -prod_y : prod_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            g_valid_reg <= 1'b0;
        else if (g_ready)
            g_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (g_ready)
        begin
            g_item_reg   <= in_item;
            g_neg_reg    <= {prod_y[56], prod_x[56]};
            g_mag_reg[0] <= abs_x[55:0];
            g_mag_reg[1] <= abs_y[55:0];
        end
    end

    genvar s;
    genvar l;
    generate
        for (s = 0; s < DIV_STAGES; s++)
        begin : g_stage
            assign dv_ready[s] = !dv_valid_reg[s] || dv_ready[s+1];

            for (l = 0; l < 2; l++)
            begin : g_lane
                if (s == 0)
                begin : g_first
                    assign dv_step_next[s][l] = div_step(22'd0, g_mag_reg[l], g_item_reg.r);
                end
                else
                begin : g_rest
                    assign dv_step_next[s][l] = div_step(dv_rem_reg[s-1][l],
                                                         dv_qd_reg[s-1][l],
                                                         dv_item_reg[s-1].r);
                end

                always_ff @(posedge clk)
                begin
                    if (dv_ready[s])
                    begin
                        dv_rem_reg[s][l] <= dv_step_next[s][l][77:56];
                        dv_qd_reg[s][l]  <= dv_step_next[s][l][55:0];
                    end
                end
            end

            if (s == 0)
            begin : g_first_ctl
                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                        dv_valid_reg[s] <= 1'b0;
                    else if (dv_ready[s])
                        dv_valid_reg[s] <= g_valid_reg;
                end

                always_ff @(posedge clk)
                begin
                    if (dv_ready[s])
                    begin
                        dv_item_reg[s] <= g_item_reg;
                        dv_neg_reg[s]  <= g_neg_reg;
                    end
                end
            end
            else
            begin : g_rest_ctl
                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                        dv_valid_reg[s] <= 1'b0;
                    else if (dv_ready[s])
                        dv_valid_reg[s] <= dv_valid_reg[s-1];
                end

                always_ff @(posedge clk)
                begin
                    if (dv_ready[s])
                    begin
                        dv_item_reg[s] <= dv_item_reg[s-1];
                        dv_neg_reg[s]  <= dv_neg_reg[s-1];
                    end
                end
            end
        end
    endgenerate

    assign kill = dv_item_reg[DIV_STAGES-1].oor || dv_item_reg[DIV_STAGES-1].zr;

    always_comb
    begin
        o_item_next.potential_energy  = dv_item_reg[DIV_STAGES-1].pot;
        o_item_next.radial_field      = dv_item_reg[DIV_STAGES-1].fld;
        o_item_next.collision_density = dv_item_reg[DIV_STAGES-1].col;
        o_item_next.out_of_range      = dv_item_reg[DIV_STAGES-1].oor;
        if (kill)
        begin
            o_item_next.field_x = '0;
            o_item_next.field_y = '0;
        end
        else
        begin
            o_item_next.field_x = quot_sat(dv_qd_reg[DIV_STAGES-1][0],
                                           dv_neg_reg[DIV_STAGES-1][0]);
            o_item_next.field_y = quot_sat(dv_qd_reg[DIV_STAGES-1][1],
                                           dv_neg_reg[DIV_STAGES-1][1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_valid_reg <= 1'b0;
        else if (dv_ready[DIV_STAGES])
            o_valid_reg <= dv_valid_reg[DIV_STAGES-1];
    end

    always_ff @(posedge clk)
    begin
        if (dv_ready[DIV_STAGES])
            o_item_reg <= o_item_next;
    end

    assign out_valid = o_valid_reg;
    assign out_item  = o_item_reg;

endmodule
